### src/contact_impulse_resolver_top_defines.svh
// Assertion macros shared by the contact impulse resolver RTL.
// Each macro expects signals named clk and arst_n in the calling module.
`ifndef CONTACT_IMPULSE_RESOLVER_TOP_DEFINES_SVH
`define CONTACT_IMPULSE_RESOLVER_TOP_DEFINES_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define CIR_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("contact resolver: implication check failed");

// The condition must never hold.
`define CIR_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("contact resolver: forbidden condition seen");

`endif

### src/cir_pkg.sv
// Shared widths, status codes, pipeline payload type and helper functions
// for the contact impulse resolver. No dependencies.
`default_nettype none
package cir_pkg;
	localparam int VelW = 32;
	localparam int NrmW = 16;
	localparam int BncW = 17;
	localparam int ImW = 32;
	localparam int InW = 264;
	localparam int OutW = 128;
	localparam int RelW = 33;
	localparam int ProdW = 49;
	localparam int VnW = 50;
	localparam int MqW = 36;
	localparam int KW = 18;
	localparam int NumW = 53;
	localparam int DenW = 33;
	localparam int JW = 52;
	localparam int HalfW = 26;
	localparam int HiW = 58;
	localparam int TW = 49;
	localparam int PW = 65;
	localparam int MagW = 51;
	localparam int DivSteps = NumW;

	localparam logic [BncW-1:0] BounceOne = 17'd65536;
	localparam logic [TW-1:0] TClamp = 49'h1_0000_0000_0000;

	typedef enum logic [1:0] {
		ST_APPLIED = 2'd0,
		ST_SEPARATING = 2'd1,
		ST_ZERO_MASS = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VelW-1:0] vax;
		logic signed [VelW-1:0] vay;
		logic signed [VelW-1:0] vbx;
		logic signed [VelW-1:0] vby;
		logic signed [NrmW-1:0] nx;
		logic signed [NrmW-1:0] ny;
		logic [ImW-1:0] ima;
		logic [ImW-1:0] imb;
		status_t status;
	} side_t;

	function automatic logic [NrmW-1:0] abs_n(input logic signed [NrmW-1:0] n);
		abs_n = n[NrmW-1] ? NrmW'(-n) : NrmW'(n);
	endfunction

	function automatic logic [TW-1:0] scale_t(input logic [HiW-1:0] hi,
			input logic [HiW-1:0] lo);
		logic [TW-1:0] sum;
		sum = TW'({hi[37:0], 10'b0}) + TW'(lo[HiW-1:16]);
		if (hi[HiW-1:38] != '0) begin
			scale_t = TClamp;
		end else if (sum > TClamp) begin
			scale_t = TClamp;
		end else begin
			scale_t = sum;
		end
	endfunction

	function automatic logic signed [VelW-1:0] sat_adj(input logic signed [VelW-1:0] v,
			input logic [MagW-1:0] mag, input logic sub);
		logic signed [MagW+1:0] s;
		s = sub ? (53'(v) - $signed({2'b0, mag})) : (53'(v) + $signed({2'b0, mag}));
		if (s > 53'sd2147483647) begin
			sat_adj = 32'sh7FFF_FFFF;
		end else if (s < -53'sd2147483648) begin
			sat_adj = 32'sh8000_0000;
		end else begin
			sat_adj = s[VelW-1:0];
		end
	endfunction
endpackage
`default_nettype wire

### src/cir_front.sv
// Front stages: relative velocity, normal projection, status decision and
// impulse numerator. Depends on cir_pkg.
`default_nettype none
module cir_front import cir_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [InW-1:0]  in_data,
	output logic                 out_valid,
	output side_t                out_side,
	output logic [NumW-1:0]      out_num,
	output logic [DenW-1:0]      out_den
);
	side_t side_in;
	side_t side_dec;
	logic [BncW-1:0] ea, eb, emin;

	logic v_s1, v_s2, v_s3, v_s4;
	side_t side_s1, side_s2, side_s3, side_s4;
	logic signed [RelW-1:0] rx_s1, ry_s1;
	logic [BncW-1:0] e_s1;
	logic [DenW-1:0] den_s1, den_s2, den_s3, den_s4;
	logic signed [ProdW-1:0] px_s2, py_s2;
	logic [KW-1:0] k_s2, k_s3;
	logic [MqW-1:0] mq_s3;
	logic [NumW-1:0] num_s4;
	logic signed [VnW-1:0] vn, negvn;

	assign side_in.vax = in_data[31:0];
	assign side_in.vay = in_data[63:32];
	assign side_in.vbx = in_data[95:64];
	assign side_in.vby = in_data[127:96];
	assign side_in.nx = in_data[143:128];
	assign side_in.ny = in_data[159:144];
	assign side_in.ima = in_data[225:194];
	assign side_in.imb = in_data[257:226];
	assign side_in.status = ST_APPLIED;
	assign ea = in_data[176:160];
	assign eb = in_data[193:177];

	always_comb begin
		emin = (ea < eb) ? ea : eb;
		if (emin > BounceOne) begin
			emin = BounceOne;
		end
	end

	assign vn = VnW'(px_s2) + VnW'(py_s2);
	assign negvn = -vn;

	always_comb begin
		side_dec = side_s2;
		if (vn > 0) begin
			side_dec.status = ST_SEPARATING;
		end else if (den_s2 == '0) begin
			side_dec.status = ST_ZERO_MASS;
		end else begin
			side_dec.status = ST_APPLIED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			rx_s1 <= RelW'(side_in.vbx) - RelW'(side_in.vax);
			ry_s1 <= RelW'(side_in.vby) - RelW'(side_in.vay);
			e_s1 <= emin;
			den_s1 <= DenW'(side_in.ima) + DenW'(side_in.imb);

			side_s2 <= side_s1;
			px_s2 <= ProdW'(rx_s1) * ProdW'(side_s1.nx);
			py_s2 <= ProdW'(ry_s1) * ProdW'(side_s1.ny);
			k_s2 <= KW'(BounceOne) + KW'(e_s1);
			den_s2 <= den_s1;

			side_s3 <= side_dec;
			mq_s3 <= negvn[VnW-1:14];
			k_s3 <= k_s2;
			den_s3 <= den_s2;

			side_s4 <= side_s3;
			num_s4 <= NumW'(k_s3) * NumW'(mq_s3);
			den_s4 <= den_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_side = side_s4;
	assign out_num = num_s4;
	assign out_den = den_s4;
endmodule
`default_nettype wire

### src/cir_div.sv
// Pipelined restoring divider, one quotient bit per stage, carrying the
// contact payload alongside. Depends on cir_pkg and the assertion macros.
`default_nettype none
`include "contact_impulse_resolver_top_defines.svh"
module cir_div import cir_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire side_t          in_side,
	input  wire logic [NumW-1:0] in_num,
	input  wire logic [DenW-1:0] in_den,
	output logic                out_valid,
	output side_t               out_side,
	output logic [JW-1:0]       out_quot
);
	logic v_s [0:DivSteps];
	side_t side_s [0:DivSteps];
	logic [NumW-1:0] num_s [0:DivSteps];
	logic [DenW-1:0] rem_s [0:DivSteps];
	logic [DenW-1:0] den_s [0:DivSteps];

	assign v_s[0] = in_valid;
	assign side_s[0] = in_side;
	assign num_s[0] = in_num;
	assign rem_s[0] = '0;
	assign den_s[0] = in_den;

	for (genvar k = 0; k < DivSteps; k++) begin : g_step
		logic [DenW:0] trial;
		logic [DenW:0] diff;
		logic qb;

		assign trial = {rem_s[k], num_s[k][NumW-1]};
		assign diff = trial - {1'b0, den_s[k]};
		assign qb = (trial >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				den_s[k+1] <= den_s[k];
				num_s[k+1] <= {num_s[k][NumW-2:0], qb};
				rem_s[k+1] <= qb ? diff[DenW-1:0] : trial[DenW-1:0];
			end
		end
	end

	assign out_valid = v_s[DivSteps];
	assign out_side = side_s[DivSteps];
	assign out_quot = num_s[DivSteps][JW-1:0];

	`CIR_ASSERT_IMPLY(a_zero_den, v_s[0] && (den_s[0] == '0), side_s[0].status != ST_APPLIED)
	`CIR_ASSERT_IMPLY(a_rem_bound, v_s[DivSteps] && (side_s[DivSteps].status == ST_APPLIED), rem_s[DivSteps] < den_s[DivSteps])
	`CIR_ASSERT_NEVER(a_quot_width, v_s[DivSteps] && (side_s[DivSteps].status == ST_APPLIED) && num_s[DivSteps][NumW-1])
endmodule
`default_nettype wire

### src/cir_back.sv
// Back stages: impulse scaled by each inverse mass, split along the normal,
// applied to the velocities with saturation (other statuses pass them unchanged). Depends on cir_pkg.
`default_nettype none
module cir_back import cir_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire side_t         in_side,
	input  wire logic [JW-1:0] in_quot,
	output logic               out_valid,
	output logic [OutW-1:0]    out_data,
	output status_t            out_status
);
	logic v_s1, v_s2, v_s3, v_s4;
	side_t side_s1, side_s2, side_s3;
	logic [HiW-1:0] hia_s1, loa_s1, hib_s1, lob_s1;
	logic [TW-1:0] ta_s2, tb_s2;
	logic [NrmW-1:0] anx_s2, any_s2;
	logic [PW-1:0] pax_s3, pay_s3, pbx_s3, pby_s3;
	logic signed [VelW-1:0] nvax_s4, nvay_s4, nvbx_s4, nvby_s4;
	status_t status_s4;
	logic applied;

	assign applied = (side_s3.status == ST_APPLIED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			hia_s1 <= HiW'(in_quot[JW-1:HalfW]) * HiW'(in_side.ima);
			loa_s1 <= HiW'(in_quot[HalfW-1:0]) * HiW'(in_side.ima);
			hib_s1 <= HiW'(in_quot[JW-1:HalfW]) * HiW'(in_side.imb);
			lob_s1 <= HiW'(in_quot[HalfW-1:0]) * HiW'(in_side.imb);

			side_s2 <= side_s1;
			ta_s2 <= scale_t(hia_s1, loa_s1);
			tb_s2 <= scale_t(hib_s1, lob_s1);
			anx_s2 <= abs_n(side_s1.nx);
			any_s2 <= abs_n(side_s1.ny);

			side_s3 <= side_s2;
			pax_s3 <= PW'(ta_s2) * PW'(anx_s2);
			pay_s3 <= PW'(ta_s2) * PW'(any_s2);
			pbx_s3 <= PW'(tb_s2) * PW'(anx_s2);
			pby_s3 <= PW'(tb_s2) * PW'(any_s2);

			status_s4 <= side_s3.status;
			if (applied) begin
				nvax_s4 <= sat_adj(side_s3.vax, pax_s3[PW-1:14], !side_s3.nx[NrmW-1]);
				nvay_s4 <= sat_adj(side_s3.vay, pay_s3[PW-1:14], !side_s3.ny[NrmW-1]);
				nvbx_s4 <= sat_adj(side_s3.vbx, pbx_s3[PW-1:14], side_s3.nx[NrmW-1]);
				nvby_s4 <= sat_adj(side_s3.vby, pby_s3[PW-1:14], side_s3.ny[NrmW-1]);
			end else begin
				nvax_s4 <= side_s3.vax;
				nvay_s4 <= side_s3.vay;
				nvbx_s4 <= side_s3.vbx;
				nvby_s4 <= side_s3.vby;
			end
		end
	end

	assign out_valid = v_s4;
	assign out_data = {nvby_s4, nvbx_s4, nvay_s4, nvax_s4};
	assign out_status = status_s4;
endmodule
`default_nettype wire

### src/contact_impulse_resolver_top.sv
// Top level of the contact impulse resolver: front stages, divider and back
// stages joined under one shared stall. Depends on cir_pkg and the cir_* modules.
//
// Channel  Direction  Contents
// s_*      in         one contact: two velocities, normal, restitutions, inverse masses
// m_*      out        updated velocities in tdata, status in tuser
//
// Every stage takes one contact per cycle unless the pipeline stalls; there are 4
// front stages, 53 divider stages (one quotient bit each) and 4 back stages.
// Reset clears only the valid bits; the pipeline comes up empty.
// When the output holds a result that is not taken, the whole pipeline
// stops and s_tready goes low; nothing is dropped or repeated.
`default_nettype none
module contact_impulse_resolver_top import cir_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	// vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y, bounce_a,
	// bounce_b, inv_mass_a, inv_mass_b, then zero fill to 264 bits
	input  wire logic [InW-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	// new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
	output logic [OutW-1:0]      m_tdata,
	// status
	output logic [1:0]           m_tuser
);
	logic en;
	logic f_valid, d_valid;
	side_t f_side, d_side;
	logic [NumW-1:0] f_num;
	logic [DenW-1:0] f_den;
	logic [JW-1:0] d_quot;
	status_t b_status;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	cir_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid), .in_data(s_tdata),
		.out_valid(f_valid), .out_side(f_side), .out_num(f_num), .out_den(f_den)
	);

	cir_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f_valid), .in_side(f_side), .in_num(f_num), .in_den(f_den),
		.out_valid(d_valid), .out_side(d_side), .out_quot(d_quot)
	);

	cir_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d_valid), .in_side(d_side), .in_quot(d_quot),
		.out_valid(m_tvalid), .out_data(m_tdata), .out_status(b_status)
	);

	assign m_tuser = b_status;
endmodule
`default_nettype wire

### tb/sv/tb_contact_impulse_resolver_top.sv
// Testbench for contact_impulse_resolver_top: random and directed contacts are driven
// on the input stream and every output transfer is checked against a local predictor.
// Depends on cir_pkg and the resolver RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_contact_impulse_resolver_top;
	import cir_pkg::*;

	localparam int NumRandom = 1530;
	localparam int PauseAt = 800;
	localparam int StallLimit = 5000;

	typedef struct packed {
		logic [31:0] vax;
		logic [31:0] vay;
		logic [31:0] vbx;
		logic [31:0] vby;
		status_t status;
	} contact_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [InW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OutW-1:0] m_tdata;
	logic [1:0] m_tuser;

	logic [InW-1:0] pending_contacts[$];
	contact_result_t expected_updates[$];
	int unsigned sent_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned result_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned quiet_cnt = 0;
	int unsigned error_cnt = 0;
	logic pause_done = 1'b0;

	contact_impulse_resolver_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	function automatic logic [31:0] sat_vel(input logic signed [127:0] v);
		if (v > 128'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end
		if (v < -128'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] body_impulse(input logic [63:0] j, input logic [63:0] im);
		logic [127:0] p;
		p = ({64'd0, j} * {64'd0, im}) >> 16;
		if (p > 128'h1_0000_0000_0000) begin
			p = 128'h1_0000_0000_0000;
		end
		return p[63:0];
	endfunction

	function automatic logic signed [127:0] axis_change(input logic [63:0] t,
			input logic signed [63:0] n);
		logic [127:0] an;
		logic signed [127:0] m;
		an = n < 0 ? 128'(-n) : 128'(n);
		m = $signed(({64'd0, t} * an) >> 14);
		return n < 0 ? -m : m;
	endfunction

	function automatic contact_result_t resolve_contact(input logic [InW-1:0] d);
		contact_result_t r;
		logic signed [63:0] vax, vay, vbx, vby, nx, ny, vn;
		logic [63:0] ea, eb, e, ima, imb, mq, j, ta, tb;
		vax = 64'($signed(d[31:0]));
		vay = 64'($signed(d[63:32]));
		vbx = 64'($signed(d[95:64]));
		vby = 64'($signed(d[127:96]));
		nx = 64'($signed(d[143:128]));
		ny = 64'($signed(d[159:144]));
		ea = 64'(d[176:160]);
		eb = 64'(d[193:177]);
		ima = 64'(d[225:194]);
		imb = 64'(d[257:226]);
		vn = (vbx - vax) * nx + (vby - vay) * ny;
		r.vax = vax[31:0];
		r.vay = vay[31:0];
		r.vbx = vbx[31:0];
		r.vby = vby[31:0];
		if (vn > 0) begin
			r.status = ST_SEPARATING;
		end else if (ima + imb == 0) begin
			r.status = ST_ZERO_MASS;
		end else begin
			r.status = ST_APPLIED;
			e = ea < eb ? ea : eb;
			if (e > 64'd65536) begin
				e = 64'd65536;
			end
			mq = 64'(-vn) >> 14;
			j = ((64'd65536 + e) * mq) / (ima + imb);
			ta = body_impulse(j, ima);
			tb = body_impulse(j, imb);
			r.vax = sat_vel(128'(vax) - axis_change(ta, nx));
			r.vay = sat_vel(128'(vay) - axis_change(ta, ny));
			r.vbx = sat_vel(128'(vbx) + axis_change(tb, nx));
			r.vby = sat_vel(128'(vby) + axis_change(tb, ny));
		end
		return r;
	endfunction

	function automatic logic [InW-1:0] pack_contact(input logic [31:0] vax, vay, vbx, vby,
			input logic [15:0] nx, ny, input logic [16:0] ea, eb,
			input logic [31:0] ima, imb);
		return {6'd0, imb, ima, eb, ea, ny, nx, vby, vbx, vay, vax};
	endfunction

	task automatic add_contact(input logic [InW-1:0] c);
		pending_contacts = {pending_contacts, c};
	endtask

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(9))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
		endcase
	endfunction

	function automatic logic [31:0] rand_mass();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return $urandom();
			default: return $urandom_range(1 << 18);
		endcase
	endfunction

	function automatic logic [16:0] rand_bounce();
		return $urandom_range(7) == 0 ? 17'($urandom()) : 17'($urandom_range(65536));
	endfunction

	function automatic logic [15:0] rand_normal();
		case ($urandom_range(7))
			0: return 16'($urandom());
			1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	initial begin
		add_contact(pack_contact(0, 0, -32'sd65536, 0, 16'sd16384, 0,
			17'd32768, 17'd65536, 32'd65536, 32'd65536));
		add_contact(pack_contact(0, 0, 32'sd65536, 0, 16'sd16384, 0,
			17'd0, 17'd0, 32'd65536, 32'd65536));
		add_contact(pack_contact(0, 0, -32'sd65536, 0, 16'sd16384, 0,
			17'd0, 17'd0, 32'd0, 32'd0));
		add_contact(pack_contact(32'sd1000, 0, -32'sd1000, 0, 0, 0,
			17'd0, 17'd0, 32'd0, 32'd0));
		add_contact(pack_contact(0, 0, 0, -32'sd65536, 0, -16'sd16384,
			17'h1FFFF, 17'h1FFFF, 32'd65536, 32'd0));
		add_contact(pack_contact(0, 0, 0, -32'sd65536, 0, 16'h8000,
			17'd65536, 17'd70000, 32'd0, 32'd65536));
		add_contact(pack_contact(32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h7FFF, 17'h1FFFF, 17'h1FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		add_contact(pack_contact(32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 17'd65536, 17'd65536,
			32'd1, 32'hFFFF_FFFF));
		add_contact(pack_contact(32'h8000_0000, 0, 32'h7FFF_FFFF, 0,
			-16'sd16384, 0, 17'd65536, 17'd65536, 32'hFFFF_FFFF, 32'd1));
		add_contact(pack_contact(32'h7FFF_FFFF, 0, 32'h8000_0000, 0,
			16'sd16384, 0, 17'd65536, 17'd65536, 32'd1, 32'd1));
		add_contact(pack_contact(0, 0, 0, 0, 16'sd11585, 16'sd11585,
			17'd0, 17'd0, 32'd1, 32'd1));
		add_contact(pack_contact(32'sd65536, 32'sd65536, 0, 0, 16'sd11585,
			-16'sd11585, 17'd40000, 17'd20000, 32'd32768, 32'd131072));
		for (int i = 0; i < NumRandom; i++) begin
			add_contact(pack_contact(rand_vel(), rand_vel(), rand_vel(),
				rand_vel(), rand_normal(), rand_normal(), rand_bounce(), rand_bounce(),
				rand_mass(), rand_mass()));
		end
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_contacts.size() != 0 || s_tvalid || accepted_cnt != result_cnt) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (error_cnt == 0 && expected_updates.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n) begin
			m_tready <= (cycle_cnt > 600 && cycle_cnt < 1400) || $urandom_range(99) >= 23;
		end
	end

	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (sent_cnt == PauseAt && !pause_done) begin
				s_tvalid <= 1'b0;
				if (!s_tvalid && accepted_cnt == result_cnt) begin
					pause_done <= 1'b1;
				end
			end else if (pending_contacts.size() != 0 &&
					((cycle_cnt > 600 && cycle_cnt < 1400) || $urandom_range(99) >= 23)) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_contacts.pop_front();
				sent_cnt <= sent_cnt + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		contact_result_t want;
		if (s_tvalid && s_tready) begin
			expected_updates = {expected_updates, resolve_contact(s_tdata)};
			accepted_cnt <= accepted_cnt + 1;
		end
		if (m_tvalid && m_tready) begin
			result_cnt <= result_cnt + 1;
			if (expected_updates.size() == 0) begin
				$error("unexpected output transfer");
				error_cnt++;
			end else begin
				want = expected_updates.pop_front();
				if (m_tdata[31:0] !== want.vax) begin
					$error("new_vel_a_x: expected %h, got %h", want.vax, m_tdata[31:0]);
					error_cnt++;
				end
				if (m_tdata[63:32] !== want.vay) begin
					$error("new_vel_a_y: expected %h, got %h", want.vay, m_tdata[63:32]);
					error_cnt++;
				end
				if (m_tdata[95:64] !== want.vbx) begin
					$error("new_vel_b_x: expected %h, got %h", want.vbx, m_tdata[95:64]);
					error_cnt++;
				end
				if (m_tdata[127:96] !== want.vby) begin
					$error("new_vel_b_y: expected %h, got %h", want.vby, m_tdata[127:96]);
					error_cnt++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					error_cnt++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			quiet_cnt <= 0;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
			if (quiet_cnt >= StallLimit) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
